// ===== rtl/gspg_pkg.sv =====
// gspg_pkg: shared constants, types and register codes of the gradient shade
// palette generator. No dependencies; used by every other file in rtl.
`timescale 1ns / 1ps

package gspg_pkg;

  localparam int CHAN_W  = 5;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int ACC_W   = 8;
  localparam int BAND_W  = 5;
  localparam int SHADE_W = 4;
  localparam int COEFF_W = 5;
  localparam int SHADES  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int LINES_DEF      = 20;
  localparam int LEAD_LINES_DEF = 2;

  localparam logic [COLOR_W-1:0] START_RESET      = 15'h684E;
  localparam logic [COLOR_W-1:0] STOP_RESET       = 15'h09DD;
  localparam logic [COEFF_W-1:0] FADE_COEFF_RESET = 5'd0;
  localparam logic [COLOR_W-1:0] FADE_COLOR_RESET = 15'h0000;
  localparam logic [COEFF_W-1:0] COEFF_MAX        = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_COLOR = 2'd0,
    REG_TARGET_COLOR = 2'd1,
    REG_FADE_COEFF   = 2'd2,
    REG_FADE_COLOR   = 2'd3
  } cfg_reg_t;

  // red in the low bits, blue in the high bits
  typedef struct packed {
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
  } rgb_t;

endpackage

// ===== rtl/gspg_if.sv =====
// gspg_if: valid/ready channel interfaces for band requests and palette items.
// Depends on gspg_pkg for field widths.
`timescale 1ns / 1ps

interface gspg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface gspg_pal_if;
  logic                         valid;
  logic                         ready;
  logic [gspg_pkg::COLOR_W-1:0] palette_color;
  logic [gspg_pkg::BAND_W-1:0]  band_index;
  logic [gspg_pkg::SHADE_W-1:0] shade_index;
  logic                         last_shade;

  modport source (output valid, output palette_color, output band_index,
                  output shade_index, output last_shade, input ready);
  modport sink (input valid, input palette_color, input band_index,
                input shade_index, input last_shade, output ready);
endinterface

// ===== rtl/gspg_shade.sv =====
// gspg_shade: darkens one band colour for a shade slot and blends it toward
// the fade colour. Combinational; depends on gspg_pkg.
`timescale 1ns / 1ps

module gspg_shade (
  input  gspg_pkg::rgb_t                band_color,
  input  logic [gspg_pkg::SHADE_W-1:0]  shade,
  input  gspg_pkg::rgb_t                fade_color,
  input  logic [gspg_pkg::COEFF_W-1:0]  fade_coeff,
  output gspg_pkg::rgb_t                color
);

  logic [2:0]                    sub;
  logic [gspg_pkg::COEFF_W-1:0]  k;

  function automatic logic [gspg_pkg::CHAN_W-1:0] blend(
    input logic [gspg_pkg::CHAN_W-1:0]  c,
    input logic [2:0]                   s,
    input logic [gspg_pkg::CHAN_W-1:0]  f,
    input logic [gspg_pkg::COEFF_W-1:0] kk
  );
    logic [gspg_pkg::CHAN_W-1:0] v;
    logic signed [5:0]           diff;
    logic signed [11:0]          prod;
    logic signed [11:0]          sh;
    v    = (c >= {2'b00, s}) ? c - {2'b00, s} : '0;
    diff = $signed({1'b0, f}) - $signed({1'b0, v});
    prod = 12'(diff * $signed({1'b0, kk}));
    sh   = prod >>> 4;
    return v + sh[gspg_pkg::CHAN_W-1:0];
  endfunction

  assign sub = {1'b0, shade[3:2]} + 3'd2;
  assign k   = (fade_coeff > gspg_pkg::COEFF_MAX) ? gspg_pkg::COEFF_MAX : fade_coeff;

  assign color.r = blend(band_color.r, sub, fade_color.r, k);
  assign color.g = blend(band_color.g, sub, fade_color.g, k);
  assign color.b = blend(band_color.b, sub, fade_color.b, k);

endmodule

// ===== rtl/gradient_shade_palette_gen_unit.sv =====
// gradient_shade_palette_gen_unit: top level of the RGB555 gradient shade
// palette generator. Depends on gspg_pkg, gspg_if and gspg_shade.
//
// Usage: each item on req asks for the next scanline band (restart = 1 goes
// back to band 0 and reloads the gradient from origin_color). For every item
// the block sends sixteen items on pal, shades 0 to 15 in order, last_shade
// marking shade 15. The first LEAD_LINES bands are black; after band
// LINES-1 the band count wraps to 0.
// Flow: the band registers take the request, then the pal output register
// takes the first shade; one shade leaves per cycle while pal is not stalled,
// and the next request is taken in the cycle that its predecessor's last
// shade is loaded, so bands follow with no gap.
// The shade datapath is one pass of subtract, 6x6 multiply and add between
// the band registers and the pal output register.
// Stalls: while pal.ready is low the output register holds its item and
// shade generation pauses; req.ready stays low until the band's last shade
// is loaded. Configuration is written through cfg_we/cfg_index/cfg_data.
// Reset: rst (synchronous) restores register defaults, band 0, empty pipe.
`timescale 1ns / 1ps

module gradient_shade_palette_gen_unit #(
  parameter int LINES      = gspg_pkg::LINES_DEF,
  parameter int LEAD_LINES = gspg_pkg::LEAD_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gspg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gspg_pkg::COLOR_W-1:0]   cfg_data,
  gspg_req_if.sink                       req,
  gspg_pal_if.source                     pal
);

  localparam int DIV    = LINES - LEAD_LINES;
  localparam int FRAC_W = 16;
  localparam logic [FRAC_W:0] RECIP = (FRAC_W + 1)'(((1 << FRAC_W) + DIV - 1) / DIV);
  localparam int ACC_W  = gspg_pkg::ACC_W;

  gspg_pkg::rgb_t                origin_color;
  gspg_pkg::rgb_t                target_color;
  logic [gspg_pkg::COEFF_W-1:0]  fade_coeff;
  gspg_pkg::rgb_t                fade_color;

  logic [gspg_pkg::BAND_W-1:0]   band_counter;
  logic [ACC_W-1:0]              red_accum;
  logic [ACC_W-1:0]              green_accum;
  logic [ACC_W-1:0]              blue_accum;

  logic                          busy;
  logic [gspg_pkg::SHADE_W-1:0]  shade_cnt;
  gspg_pkg::rgb_t                band_color;
  logic [gspg_pkg::BAND_W-1:0]   band_idx;

  logic                          pal_valid;
  gspg_pkg::rgb_t                shade_color;

  logic                          load_ok;
  logic                          emit;
  logic                          last_emit;
  logic                          accept;

  logic [gspg_pkg::BAND_W-1:0]   band_cur;
  logic [gspg_pkg::BAND_W:0]     band_inc;
  logic                          is_grad;
  logic                          wrap;
  logic [ACC_W-1:0]              start8_r, start8_g, start8_b;
  logic [ACC_W-1:0]              eff_r, eff_g, eff_b;
  logic [ACC_W-1:0]              red_accum_next, green_accum_next, blue_accum_next;

  function automatic logic [ACC_W-1:0] step_of(
    input logic [gspg_pkg::CHAN_W-1:0] stop5,
    input logic [gspg_pkg::CHAN_W-1:0] start5
  );
    logic signed [9:0]   diff;
    logic                neg;
    logic [ACC_W-1:0]    mag;
    logic [ACC_W+FRAC_W:0] prod;
    logic [ACC_W-1:0]    q;
    diff = $signed({2'b00, stop5, 3'b000}) - $signed({2'b00, start5, 3'b000});
    neg  = diff[9];
    mag  = neg ? ACC_W'(-diff) : ACC_W'(diff);
    prod = (ACC_W + FRAC_W + 1)'(mag * RECIP);
    q    = prod[ACC_W+FRAC_W-1:FRAC_W];
    return neg ? ACC_W'(-q) : q;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_color <= gspg_pkg::START_RESET;
      target_color <= gspg_pkg::STOP_RESET;
      fade_coeff   <= gspg_pkg::FADE_COEFF_RESET;
      fade_color   <= gspg_pkg::FADE_COLOR_RESET;
    end else if (cfg_we) begin
      unique case (gspg_pkg::cfg_reg_t'(cfg_index))
        gspg_pkg::REG_ORIGIN_COLOR: origin_color <= cfg_data;
        gspg_pkg::REG_TARGET_COLOR: target_color <= cfg_data;
        gspg_pkg::REG_FADE_COEFF:   fade_coeff   <= cfg_data[gspg_pkg::COEFF_W-1:0];
        gspg_pkg::REG_FADE_COLOR:   fade_color   <= cfg_data;
      endcase
    end
  end

  // handshake
  assign load_ok   = !pal_valid || pal.ready;
  assign emit      = busy && load_ok;
  assign last_emit = emit && (shade_cnt == gspg_pkg::SHADE_W'(gspg_pkg::SHADES - 1));
  assign req.ready = !busy || last_emit;
  assign accept    = req.valid && req.ready;

  // band step
  assign start8_r = {origin_color.r, 3'b000};
  assign start8_g = {origin_color.g, 3'b000};
  assign start8_b = {origin_color.b, 3'b000};

  assign band_cur = req.restart ? '0 : band_counter;
  assign eff_r    = req.restart ? start8_r : red_accum;
  assign eff_g    = req.restart ? start8_g : green_accum;
  assign eff_b    = req.restart ? start8_b : blue_accum;
  assign is_grad  = ({1'b0, band_cur} >= (gspg_pkg::BAND_W + 1)'(LEAD_LINES));
  assign band_inc = {1'b0, band_cur} + 1'b1;
  assign wrap     = (band_inc >= (gspg_pkg::BAND_W + 1)'(LINES));

  always_comb begin
    if (wrap) begin
      red_accum_next   = start8_r;
      green_accum_next = start8_g;
      blue_accum_next  = start8_b;
    end else if (is_grad) begin
      red_accum_next   = eff_r + step_of(target_color.r, origin_color.r);
      green_accum_next = eff_g + step_of(target_color.g, origin_color.g);
      blue_accum_next  = eff_b + step_of(target_color.b, origin_color.b);
    end else begin
      red_accum_next   = eff_r;
      green_accum_next = eff_g;
      blue_accum_next  = eff_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_counter <= '0;
      red_accum    <= {gspg_pkg::START_RESET[4:0], 3'b000};
      green_accum  <= {gspg_pkg::START_RESET[9:5], 3'b000};
      blue_accum   <= {gspg_pkg::START_RESET[14:10], 3'b000};
    end else if (accept) begin
      band_counter <= wrap ? '0 : band_inc[gspg_pkg::BAND_W-1:0];
      red_accum    <= red_accum_next;
      green_accum  <= green_accum_next;
      blue_accum   <= blue_accum_next;
    end
  end

  // band registers
  always_ff @(posedge clk) begin
    if (accept) begin
      band_idx     <= band_cur;
      band_color.r <= is_grad ? eff_r[ACC_W-1:3] : '0;
      band_color.g <= is_grad ? eff_g[ACC_W-1:3] : '0;
      band_color.b <= is_grad ? eff_b[ACC_W-1:3] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      shade_cnt <= '0;
    end else if (accept) begin
      busy      <= 1'b1;
      shade_cnt <= '0;
    end else if (emit) begin
      busy      <= !last_emit;
      shade_cnt <= shade_cnt + 1'b1;
    end
  end

  gspg_shade u_shade (
    .band_color (band_color),
    .shade      (shade_cnt),
    .fade_color (fade_color),
    .fade_coeff (fade_coeff),
    .color      (shade_color)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= 1'b0;
    end else if (emit) begin
      pal_valid <= 1'b1;
    end else if (pal.ready) begin
      pal_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pal.palette_color <= shade_color;
      pal.band_index    <= band_idx;
      pal.shade_index   <= shade_cnt;
      pal.last_shade    <= (shade_cnt == gspg_pkg::SHADE_W'(gspg_pkg::SHADES - 1));
    end
  end

  assign pal.valid = pal_valid;

endmodule

// ===== rtl/gspg_checker.sv =====
// gspg_checker: port-level assertions for the palette generator, bound to
// gradient_shade_palette_gen_unit. Depends on gspg_pkg.
`timescale 1ns / 1ps

module gspg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         pal_valid,
  input logic                         pal_ready,
  input logic [gspg_pkg::COLOR_W-1:0] pal_color,
  input logic [gspg_pkg::BAND_W-1:0]  pal_band,
  input logic [gspg_pkg::SHADE_W-1:0] pal_shade,
  input logic                         pal_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !pal_valid)
    else $error("pal valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pal_valid && !pal_ready |=> pal_valid && $stable(pal_color) && $stable(pal_band)
      && $stable(pal_shade) && $stable(pal_last))
    else $error("stalled pal item changed");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    pal_valid |-> pal_last == (pal_shade == gspg_pkg::SHADE_W'(gspg_pkg::SHADES - 1)))
    else $error("last_shade does not match shade index");

  a_shade_follow: assert property (@(posedge clk) disable iff (rst)
    pal_valid && pal_ready && !pal_last |=> pal_valid
      && pal_band == $past(pal_band)
      && pal_shade == gspg_pkg::SHADE_W'($past(pal_shade) + 1'b1))
    else $error("shade sequence broken within band");

  a_no_req_mid_band: assert property (@(posedge clk) disable iff (rst)
    pal_valid && (pal_shade < gspg_pkg::SHADE_W'(gspg_pkg::SHADES - 2)) && req_valid
      |-> !req_ready)
    else $error("request taken while band still in progress");

endmodule

bind gradient_shade_palette_gen_unit gspg_checker u_gspg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .pal_valid (pal.valid),
  .pal_ready (pal.ready),
  .pal_color (pal.palette_color),
  .pal_band  (pal.band_index),
  .pal_shade (pal.shade_index),
  .pal_last  (pal.last_shade)
);

// ===== bench/tb_gradient_shade_palette_gen_unit.sv =====
// tb_gradient_shade_palette_gen_unit: self-checking bench for the palette generator.
// A directed table runs first, then random band requests; each palette item is compared
// with a local band/shade predictor. Depends on gspg_pkg, gspg_if and the rtl top level.
`timescale 1ns / 1ps

module tb_gradient_shade_palette_gen_unit;

  localparam int NUM_LINES      = gspg_pkg::LINES_DEF;
  localparam int NUM_LEAD       = gspg_pkg::LEAD_LINES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_WAIT       = 20;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BANDS    = 44;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_N          = 34;

  localparam logic [gspg_pkg::COLOR_W-1:0] COLOR_BLACK = 15'h0000;
  localparam logic [gspg_pkg::COLOR_W-1:0] COLOR_WHITE = 15'h7FFF;

  typedef enum logic {ROW_BAND, ROW_CFG} row_kind_t;

  // data is the register value on a write row, the typed colour on a band row
  typedef struct {
    row_kind_t                    kind;
    logic                         restart;
    bit                           typed;
    gspg_pkg::cfg_reg_t           idx;
    logic [gspg_pkg::COLOR_W-1:0] data;
    logic [gspg_pkg::BAND_W-1:0]  band;
  } dir_row_t;

  typedef struct packed {
    logic [gspg_pkg::COLOR_W-1:0] color;
    logic [gspg_pkg::BAND_W-1:0]  band;
    logic [gspg_pkg::SHADE_W-1:0] shade;
    logic                         last;
  } pal_item_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [gspg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gspg_pkg::COLOR_W-1:0]   cfg_data;

  gspg_req_if req ();
  gspg_pal_if pal ();

  gradient_shade_palette_gen_unit #(
    .LINES(NUM_LINES),
    .LEAD_LINES(NUM_LEAD)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req),
    .pal(pal)
  );

  // predictor state and register copies
  logic [gspg_pkg::COLOR_W-1:0] sh_start;
  logic [gspg_pkg::COLOR_W-1:0] sh_stop;
  logic [gspg_pkg::COEFF_W-1:0] sh_coeff;
  logic [gspg_pkg::COLOR_W-1:0] sh_fade;
  int                           band_cnt;
  logic [gspg_pkg::ACC_W-1:0]   acc_r;
  logic [gspg_pkg::ACC_W-1:0]   acc_g;
  logic [gspg_pkg::ACC_W-1:0]   acc_b;

  pal_item_t shade_q[$];

  int  errs;
  int  checked;
  int  bands_sent;
  int  reg_writes;
  bit  quiet;
  bit  req_up;
  bit  cfg_up;

  dir_row_t dir_tab [DIR_N] = '{
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd1},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b1, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd1},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_WHITE, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_TARGET_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b1, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd1},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COEFF,   15'd31,      5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COLOR,   COLOR_WHITE, 5'd0},
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_WHITE, 5'd4},
    '{ROW_BAND, 1'b1, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_WHITE, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COEFF,   15'd16,      5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COLOR,   COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd1},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COEFF,   15'd8,       5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COLOR,   COLOR_WHITE, 5'd0},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_TARGET_COLOR, COLOR_WHITE, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COEFF,   15'd0,       5'd0},
    '{ROW_BAND, 1'b1, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b1, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd1},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, 15'h1234,    5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COEFF,   15'd5,       5'd0},
    '{ROW_CFG,  1'b0, 1'b0, gspg_pkg::REG_FADE_COLOR,   15'h5555,    5'd0},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0},
    '{ROW_BAND, 1'b0, 1'b0, gspg_pkg::REG_ORIGIN_COLOR, COLOR_BLACK, 5'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void load_grad();
    acc_r = {sh_start[4:0], 3'b000};
    acc_g = {sh_start[9:5], 3'b000};
    acc_b = {sh_start[14:10], 3'b000};
  endfunction

  function automatic void reset_model();
    sh_start = gspg_pkg::START_RESET;
    sh_stop  = gspg_pkg::STOP_RESET;
    sh_coeff = gspg_pkg::FADE_COEFF_RESET;
    sh_fade  = gspg_pkg::FADE_COLOR_RESET;
    band_cnt = 0;
    load_grad();
  endfunction

  function automatic logic [gspg_pkg::ACC_W-1:0] grad_step(input int lo);
    int diff;
    int q;
    diff = int'({sh_stop[lo+:gspg_pkg::CHAN_W], 3'b000})
         - int'({sh_start[lo+:gspg_pkg::CHAN_W], 3'b000});
    q = diff / (NUM_LINES - NUM_LEAD);
    return q[gspg_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [gspg_pkg::CHAN_W-1:0] shade_chan(
    input logic [gspg_pkg::CHAN_W-1:0] c, input int sub,
    input logic [gspg_pkg::CHAN_W-1:0] f, input int k);
    int v;
    int prod;
    v = (int'(c) >= sub) ? int'(c) - sub : 0;
    prod = (int'(f) - v) * k;
    return gspg_pkg::CHAN_W'(v + (prod >>> 4));
  endfunction

  function automatic void predict_band(input logic rs, input bit typed,
                                       input logic [gspg_pkg::COLOR_W-1:0] tc,
                                       input logic [gspg_pkg::BAND_W-1:0] tb);
    int             band;
    int             k;
    int             sub;
    int             j;
    gspg_pkg::rgb_t base;
    gspg_pkg::rgb_t fc;
    gspg_pkg::rgb_t px;
    pal_item_t      item;
    base = '0;
    fc = sh_fade;
    if (rs) begin
      band_cnt = 0;
      load_grad();
    end
    band = band_cnt;
    if (band >= NUM_LEAD) begin
      base.r = acc_r[7:3];
      base.g = acc_g[7:3];
      base.b = acc_b[7:3];
      acc_r = acc_r + grad_step(0);
      acc_g = acc_g + grad_step(5);
      acc_b = acc_b + grad_step(10);
    end
    k = (sh_coeff > gspg_pkg::COEFF_MAX) ? int'(gspg_pkg::COEFF_MAX) : int'(sh_coeff);
    for (j = 0; j < gspg_pkg::SHADES; j++) begin
      sub = j / 4 + 2;
      px.r = shade_chan(base.r, sub, fc.r, k);
      px.g = shade_chan(base.g, sub, fc.g, k);
      px.b = shade_chan(base.b, sub, fc.b, k);
      item.color = typed ? tc : px;
      item.band  = typed ? tb : gspg_pkg::BAND_W'(band);
      item.shade = gspg_pkg::SHADE_W'(j);
      item.last  = (j == gspg_pkg::SHADES - 1);
      shade_q.push_back(item);
    end
    band_cnt = band + 1;
    if (band_cnt >= NUM_LINES) begin
      band_cnt = 0;
      load_grad();
    end
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  function automatic logic [gspg_pkg::COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0: return COLOR_BLACK;
      1: return COLOR_WHITE;
      default: return gspg_pkg::COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [gspg_pkg::COLOR_W-1:0] pick_coeff();
    logic [gspg_pkg::COEFF_W-1:0] k;
    case ($urandom_range(0, 5))
      0: k = 5'd0;
      1: k = gspg_pkg::COEFF_MAX;
      2: k = 5'd31;
      default: k = gspg_pkg::COEFF_W'($urandom_range(0, 31));
    endcase
    return {(gspg_pkg::COLOR_W - gspg_pkg::COEFF_W)'($urandom), k};
  endfunction

  task automatic release_cfg();
    if (cfg_up) begin
      cfg_we <= 1'b0;
      cfg_up = 1'b0;
    end
  endtask

  task automatic write_reg(input gspg_pkg::cfg_reg_t idx,
                           input logic [gspg_pkg::COLOR_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_up    = 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      gspg_pkg::REG_ORIGIN_COLOR: sh_start = d;
      gspg_pkg::REG_TARGET_COLOR: sh_stop  = d;
      gspg_pkg::REG_FADE_COEFF:   sh_coeff = d[gspg_pkg::COEFF_W-1:0];
      gspg_pkg::REG_FADE_COLOR:   sh_fade  = d;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic drain_bands();
    if (req_up) begin
      req.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_band(input logic rs, input int gap, input bit typed,
                           input logic [gspg_pkg::COLOR_W-1:0] tc,
                           input logic [gspg_pkg::BAND_W-1:0] tb);
    release_cfg();
    if (gap > 0) begin
      if (req_up) begin
        req.valid <= 1'b0;
        req_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    if (!req_up) begin
      req.valid <= 1'b1;
      req_up = 1'b1;
    end
    req.restart <= rs;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_band(rs, typed, tc, tb);
    bands_sent++;
  endtask

  // palette sink: random stall bursts and item checking
  initial begin
    int        stall_left;
    pal_item_t want;
    stall_left = 0;
    pal.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pal.valid && pal.ready) begin
        if (shade_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("unexpected palette item: color %h band %0d shade %0d last %b",
                     pal.palette_color, pal.band_index, pal.shade_index, pal.last_shade);
        end else begin
          want = shade_q.pop_front();
          checked++;
          if (pal.palette_color !== want.color || pal.band_index !== want.band ||
              pal.shade_index !== want.shade || pal.last_shade !== want.last) begin
            errs++;
            if (errs <= MAX_REPORTS) begin
              $display("palette mismatch: expected color %h band %0d shade %0d last %b",
                       want.color, want.band, want.shade, want.last);
              $display("                  got      color %h band %0d shade %0d last %b",
                       pal.palette_color, pal.band_index, pal.shade_index,
                       pal.last_shade);
            end
          end
        end
      end
      if (quiet) begin
        stall_left = 0;
        pal.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pal.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        pal.ready <= 1'b0;
      end else begin
        pal.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (pal.valid && pal.ready) || cfg_we) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int  i;
    int  p;
    int  n;
    logic rs;
    errs       = 0;
    checked    = 0;
    bands_sent = 0;
    reg_writes = 0;
    quiet      = 1'b0;
    req_up     = 1'b0;
    cfg_up     = 1'b0;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= gspg_pkg::REG_ORIGIN_COLOR;
    cfg_data    <= '0;
    req.valid   <= 1'b0;
    req.restart <= 1'b0;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_bands();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_band(dir_tab[i].restart, pick_gap(), dir_tab[i].typed, dir_tab[i].data,
                  dir_tab[i].band);
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      quiet = (p == RAND_PHASES - 1) || ($urandom_range(0, 4) == 0);
      drain_bands();
      write_reg(gspg_pkg::REG_ORIGIN_COLOR, pick_color());
      write_reg(gspg_pkg::REG_TARGET_COLOR, pick_color());
      write_reg(gspg_pkg::REG_FADE_COEFF, pick_coeff());
      write_reg(gspg_pkg::REG_FADE_COLOR, pick_color());
      for (n = 0; n < PHASE_BANDS; n++) begin
        rs = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
        send_band(rs, pick_gap(), 1'b0, COLOR_BLACK, 5'd0);
      end
    end

    drain_bands();
    release_cfg();
    repeat (END_WAIT) @(posedge clk);
    if (shade_q.size() != 0) errs++;
    $display("%0d band requests, %0d register writes, %0d items checked, %0d failures",
             bands_sent, reg_writes, checked, errs);
    $display("covered lead bands, band wrap, restart, step of either sign and fade saturation");
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gspg_pkg.sv
rtl/gspg_if.sv
rtl/gspg_shade.sv
rtl/gradient_shade_palette_gen_unit.sv
rtl/gspg_checker.sv
bench/tb_gradient_shade_palette_gen_unit.sv
